// ===== sv/hma_pkg.sv =====
// ----------------------------------------------------------------------------
// hma_pkg
// Shared types and fixed constants of the max-weight assignment unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hma_pkg;

	// Fixed field widths of the streaming and configuration ports
	localparam int SIZE_BITS    = 5;
	localparam int IDX_BITS     = 4;
	localparam int IN_DATA_BITS = 16;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SINIT,
		ST_PINIT,
		ST_PSTART,
		ST_NRD,
		ST_NCHK,
		ST_ROWPOT,
		ST_SCAN,
		ST_DRAIN,
		ST_U0,
		ST_U1,
		ST_U2,
		ST_G0,
		ST_G1,
		ST_G2,
		ST_INV0,
		ST_INV1,
		ST_OUT0,
		ST_OUT1
	} hma_state_t;

	// Control that travels with one column read into the slack unit
	typedef struct packed {
		logic valid;
		logic visited;
	} hma_ctl_t;

endpackage

`default_nettype wire

// ===== sv/hma_slack_unit.sv =====
// ----------------------------------------------------------------------------
// hma_slack_unit
// Two-stage reduced-cost and slack update with running minimum tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module hma_slack_unit
	import hma_pkg::*;
#(
	parameter int WB = 16,
	parameter int SW = 26,
	parameter int CW = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clear,
	input  wire hma_ctl_t             ctl,
	input  wire logic [CW-1:0]        col,
	input  wire logic [WB-1:0]        largest,
	input  wire logic [WB-1:0]        weight,
	input  wire logic signed [SW-1:0] urow,
	input  wire logic signed [SW-1:0] colpot,
	input  wire logic signed [SW-1:0] slack,
	output logic                      slack_we,
	output logic [CW-1:0]             wcol,
	output logic signed [SW-1:0]      wslack,
	output logic signed [SW-1:0]      delta,
	output logic [CW-1:0]             next_col,
	output logic                      busy
);

	localparam logic signed [SW-1:0] INF = {1'b0, {(SW-1){1'b1}}};

	hma_ctl_t               ctl_s2;
	logic [CW-1:0]          col_s2;
	logic signed [SW-1:0]   c_s2;
	logic signed [SW-1:0]   slack_s2;
	logic signed [SW-1:0]   cost_s1;
	logic signed [SW-1:0]   delta_q;
	logic [CW-1:0]          next_q;
	logic                   lt;
	logic signed [SW-1:0]   nslack;
	logic                   take;

	// Reduced cost: largest - weight - u[row] - v[col]
	assign cost_s1 = $signed({{(SW-WB){1'b0}}, largest})
		- $signed({{(SW-WB){1'b0}}, weight}) - urow - colpot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		col_s2   <= col;
		c_s2     <= cost_s1;
		slack_s2 <= slack;
	end

	always_comb begin
		lt       = c_s2 < slack_s2;
		nslack   = lt ? c_s2 : slack_s2;
		slack_we = ctl_s2.valid && !ctl_s2.visited && lt;
		take     = ctl_s2.valid && !ctl_s2.visited && (nslack < delta_q);
		wcol     = col_s2;
		wslack   = c_s2;
		delta    = delta_q;
		next_col = next_q;
		busy     = ctl_s2.valid;
	end

	// Hold the smallest slack; strict compare keeps the lowest column on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= INF;
			next_q  <= '0;
		end else if (clear) begin
			delta_q <= INF;
			next_q  <= '0;
		end else if (take) begin
			delta_q <= nslack;
			next_q  <= col_s2;
		end
	end

endmodule

`default_nettype wire

// ===== sv/hungarian_max_weight_assignment_unit.sv =====
// ----------------------------------------------------------------------------
// hungarian_max_weight_assignment_unit
// Maximum-weight square assignment by the shortest-augmenting-path method.
// ----------------------------------------------------------------------------
// Weights stream in row-major order, one transaction per cycle, while the unit
// is loading and no size write is offered. After the n*n-th weight the unit
// solves the minimum-cost assignment on cost = largest weight - weight and
// then emits one transaction per row, in row order, with tlast on the final
// row. A solve first clears the n+1 column and row entries, then per row clears
// the slack and visited entries and runs augmenting steps; each step scans the
// slacks and then updates the potentials column by column, all through the
// single read port of the column store. The result list is then built and
// emitted row by row. No new weight is taken until the solve is done and the
// last result is staged in the output register. matrix_size is written only
// while loading; a write drops any partial load. A size of 0 acts as 1 and a
// size above MAX_SIZE acts as MAX_SIZE.
// ----------------------------------------------------------------------------
`default_nettype none

module hungarian_max_weight_assignment_unit
	import hma_pkg::*;
#(
	parameter int MAX_SIZE    = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write channel
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [SIZE_BITS-1:0]    cfg_data,      // matrix_size
	// weight stream
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [IN_DATA_BITS-1:0] s_axis_tdata,  // [15:0] weight
	// assignment stream
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [2*IDX_BITS-1:0]        m_axis_tdata,  // [3:0] row_index, [7:4] column_index
	output logic                         m_axis_tlast   // last
);

	// Internal weight width: the port carries 16 bits
	localparam int WB  = (WEIGHT_BITS < IN_DATA_BITS) ? WEIGHT_BITS : IN_DATA_BITS;
	// Signed width for costs, potentials and slack
	localparam int SW  = WB + 10;
	// Column/row index width (0..MAX_SIZE)
	localparam int CW  = $clog2(MAX_SIZE + 1);
	localparam int NSQ = MAX_SIZE * MAX_SIZE;
	localparam int WA  = (NSQ > 1) ? $clog2(NSQ) : 1;
	localparam int LCW = $clog2(NSQ + 1);
	localparam int DEP = MAX_SIZE + 1;
	localparam logic signed [SW-1:0] INF = {1'b0, {(SW-1){1'b1}}};

	hma_state_t state_q, state_d;

	logic [SIZE_BITS-1:0] size_q;
	logic [CW-1:0]        n_eff;
	logic [LCW-1:0]       nsq;
	logic [LCW-1:0]       load_count_q;
	logic [WB-1:0]        largest_q;
	logic [WB-1:0]        w_in;

	// Stores
	logic [WB-1:0]        weight_mem  [NSQ];
	logic signed [SW-1:0] colpot_mem  [DEP];
	logic [CW-1:0]        match_mem   [DEP];
	logic [CW-1:0]        link_mem    [DEP];
	logic signed [SW-1:0] slack_mem   [DEP];
	logic                 vis_mem     [DEP];
	logic signed [SW-1:0] row_mem     [DEP];

	// Registered read data
	logic [WB-1:0]        w_rd;
	logic signed [SW-1:0] colpot_rd;
	logic [CW-1:0]        match_rd;
	logic [CW-1:0]        link_rd;
	logic signed [SW-1:0] slack_rd;
	logic                 vis_rd;
	logic signed [SW-1:0] row_rd;

	// Port controls
	logic [WA-1:0]        w_raddr, w_waddr;
	logic                 w_we;
	logic [CW-1:0]        col_raddr, row_raddr;
	logic                 colpot_we, match_we, link_we, slack_we, vis_we, row_we;
	logic [CW-1:0]        colpot_wa, match_wa, link_wa, slack_wa, vis_wa, row_wa;
	logic signed [SW-1:0] colpot_wd, slack_wd, row_wd;
	logic [CW-1:0]        match_wd, link_wd;
	logic                 vis_wd;

	// Sequencer registers
	logic [CW-1:0]        j_q, r_q, cur_q, prev_q, m_q;
	logic [WA-1:0]        base_q;
	logic signed [SW-1:0] urow_q;
	logic                 rd_valid_s1;
	logic [CW-1:0]        j_s1;
	logic [LCW-1:0]       base_full;

	// Slack unit
	hma_ctl_t             su_ctl;
	logic                 su_clear, su_we, su_busy;
	logic [CW-1:0]        su_wcol, su_next;
	logic signed [SW-1:0] su_wslack, su_delta;

	// Output register
	logic                 out_valid_q;
	logic [2*IDX_BITS-1:0] out_data_q;
	logic                 out_last_q;
	logic                 out_load;

	logic in_acc, cfg_acc;

	// Effective size: clamp 0 to 1 and large values to MAX_SIZE
	always_comb begin
		if (size_q == '0) begin
			n_eff = CW'(1);
		end else if (int'(size_q) > MAX_SIZE) begin
			n_eff = CW'(MAX_SIZE);
		end else begin
			n_eff = CW'(size_q);
		end
		nsq = LCW'(n_eff) * LCW'(n_eff);
	end

	assign w_in          = s_axis_tdata[WB-1:0];
	assign cfg_ready     = (state_q == ST_LOAD);
	assign s_axis_tready = (state_q == ST_LOAD) && !cfg_valid;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign base_full     = LCW'(match_rd - CW'(1)) * LCW'(n_eff);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// Scan data feeds the slack unit in the cycle after its read is issued
	assign su_ctl.valid   = rd_valid_s1;
	assign su_ctl.visited = vis_rd;

	hma_slack_unit #(
		.WB (WB),
		.SW (SW),
		.CW (CW)
	) u_slack (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (su_clear),
		.ctl      (su_ctl),
		.col      (j_s1),
		.largest  (largest_q),
		.weight   (w_rd),
		.urow     (urow_q),
		.colpot   (colpot_rd),
		.slack    (slack_rd),
		.slack_we (su_we),
		.wcol     (su_wcol),
		.wslack   (su_wslack),
		.delta    (su_delta),
		.next_col (su_next),
		.busy     (su_busy)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and store port control
	always_comb begin
		state_d   = state_q;
		w_raddr   = base_q + WA'(j_q - CW'(1));
		w_waddr   = load_count_q[WA-1:0];
		w_we      = 1'b0;
		col_raddr = j_q;
		row_raddr = r_q;
		colpot_we = 1'b0; colpot_wa = j_q; colpot_wd = '0;
		match_we  = 1'b0; match_wa  = j_q; match_wd  = '0;
		link_we   = 1'b0; link_wa   = j_q; link_wd   = '0;
		slack_we  = 1'b0; slack_wa  = j_q; slack_wd  = INF;
		vis_we    = 1'b0; vis_wa    = j_q; vis_wd    = 1'b0;
		row_we    = 1'b0; row_wa    = j_q; row_wd    = '0;
		su_clear  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					w_we = 1'b1;
					if (load_count_q + LCW'(1) == nsq) begin
						state_d = ST_SINIT;
					end
				end
			end
			ST_SINIT: begin
				// clear potentials, matches and back-links for columns and rows
				colpot_we = 1'b1;
				match_we  = 1'b1;
				link_we   = 1'b1;
				row_we    = 1'b1;
				if (j_q == n_eff) begin
					state_d = ST_PINIT;
				end
			end
			ST_PINIT: begin
				slack_we = 1'b1;
				vis_we   = 1'b1;
				if (j_q == n_eff) begin
					state_d = ST_PSTART;
				end
			end
			ST_PSTART: begin
				// column 0 carries the row being inserted
				match_we = 1'b1;
				match_wa = '0;
				match_wd = r_q;
				state_d  = ST_NRD;
			end
			ST_NRD: begin
				col_raddr = cur_q;
				state_d   = ST_NCHK;
			end
			ST_NCHK: begin
				if (match_rd == '0) begin
					state_d = ST_G0;
				end else begin
					vis_we    = 1'b1;
					vis_wa    = cur_q;
					vis_wd    = 1'b1;
					row_raddr = match_rd;
					state_d   = ST_ROWPOT;
				end
			end
			ST_ROWPOT: begin
				su_clear = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (j_q == n_eff) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !su_busy) begin
					state_d = ST_U0;
				end
			end
			ST_U0: begin
				state_d = ST_U1;
			end
			ST_U1: begin
				if (vis_rd) begin
					colpot_we = 1'b1;
					colpot_wd = colpot_rd - su_delta;
					row_raddr = match_rd;
					state_d   = ST_U2;
				end else begin
					slack_we = 1'b1;
					slack_wd = slack_rd - su_delta;
					state_d  = (j_q == n_eff) ? ST_NRD : ST_U0;
				end
			end
			ST_U2: begin
				row_we  = 1'b1;
				row_wa  = m_q;
				row_wd  = row_rd + su_delta;
				state_d = (j_q == n_eff) ? ST_NRD : ST_U0;
			end
			ST_G0: begin
				col_raddr = cur_q;
				state_d   = ST_G1;
			end
			ST_G1: begin
				col_raddr = link_rd;
				state_d   = ST_G2;
			end
			ST_G2: begin
				match_we = 1'b1;
				match_wa = cur_q;
				match_wd = match_rd;
				if (prev_q != '0) begin
					state_d = ST_G0;
				end else if (r_q == n_eff) begin
					state_d = ST_INV0;
				end else begin
					state_d = ST_PINIT;
				end
			end
			ST_INV0: begin
				state_d = ST_INV1;
			end
			ST_INV1: begin
				// row store now maps row to its assigned column
				row_we  = 1'b1;
				row_wa  = match_rd;
				row_wd  = SW'(j_q - CW'(1));
				state_d = (j_q == n_eff) ? ST_OUT0 : ST_INV0;
			end
			ST_OUT0: begin
				state_d = ST_OUT1;
			end
			ST_OUT1: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = (r_q == n_eff) ? ST_LOAD : ST_OUT0;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		// scan write-back from the slack unit
		if (su_we) begin
			slack_we = 1'b1;
			slack_wa = su_wcol;
			slack_wd = su_wslack;
			link_we  = 1'b1;
			link_wa  = su_wcol;
			link_wd  = cur_q;
		end
	end

	// Stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (w_we) weight_mem[w_waddr] <= w_in;
		w_rd <= weight_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (colpot_we) colpot_mem[colpot_wa] <= colpot_wd;
		if (match_we)  match_mem[match_wa]   <= match_wd;
		if (link_we)   link_mem[link_wa]     <= link_wd;
		if (slack_we)  slack_mem[slack_wa]   <= slack_wd;
		if (vis_we)    vis_mem[vis_wa]       <= vis_wd;
		colpot_rd <= colpot_mem[col_raddr];
		match_rd  <= match_mem[col_raddr];
		link_rd   <= link_mem[col_raddr];
		slack_rd  <= slack_mem[col_raddr];
		vis_rd    <= vis_mem[col_raddr];
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_wa] <= row_wd;
		row_rd <= row_mem[row_raddr];
	end

	// Payload registers of the sequencer
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		case (state_q)
			ST_NCHK:   base_q <= base_full[WA-1:0];
			ST_ROWPOT: urow_q <= row_rd;
			ST_U1:     m_q    <= match_rd;
			ST_G1:     prev_q <= link_rd;
			default: begin
			end
		endcase
	end

	// Control registers: counters, load state, size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= SIZE_BITS'(16);
			load_count_q <= '0;
			largest_q    <= '0;
			j_q          <= '0;
			r_q          <= '0;
			cur_q        <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (cfg_acc) begin
				size_q       <= cfg_data;
				load_count_q <= '0;
				largest_q    <= '0;
			end
			if (in_acc) begin
				if (w_in > largest_q) largest_q <= w_in;
				if (load_count_q + LCW'(1) == nsq) begin
					load_count_q <= '0;
					j_q          <= '0;
				end else begin
					load_count_q <= load_count_q + LCW'(1);
				end
			end
			case (state_q)
				ST_SINIT: begin
					if (j_q == n_eff) begin
						j_q <= '0;
						r_q <= CW'(1);
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_PINIT: begin
					j_q <= (j_q == n_eff) ? j_q : j_q + CW'(1);
				end
				ST_PSTART: begin
					cur_q <= '0;
				end
				ST_ROWPOT: begin
					j_q <= CW'(1);
				end
				ST_SCAN: begin
					if (j_q != n_eff) j_q <= j_q + CW'(1);
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !su_busy) j_q <= '0;
				end
				ST_U1: begin
					if (!vis_rd) begin
						if (j_q == n_eff) begin
							cur_q <= su_next;
						end else begin
							j_q <= j_q + CW'(1);
						end
					end
				end
				ST_U2: begin
					if (j_q == n_eff) begin
						cur_q <= su_next;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_G2: begin
					cur_q <= prev_q;
					if (prev_q == '0) begin
						if (r_q == n_eff) begin
							j_q <= CW'(1);
						end else begin
							r_q <= r_q + CW'(1);
							j_q <= '0;
						end
					end
				end
				ST_INV1: begin
					if (j_q == n_eff) begin
						r_q <= CW'(1);
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_OUT1: begin
					if (out_load) begin
						if (r_q == n_eff) begin
							largest_q <= '0;
						end else begin
							r_q <= r_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: hold a result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {row_rd[IDX_BITS-1:0], IDX_BITS'(r_q - CW'(1))};
			out_last_q <= (r_q == n_eff);
		end
	end

`ifndef ASSERT_OFF
	// Scan write-backs only land on real columns
	a_scan_col: assert property (@(posedge clk) disable iff (!arst_n)
		su_we |-> (su_wcol != '0) && (su_wcol <= n_eff))
		else $error("slack write outside columns 1..n");

	// A load never runs past the matrix
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (load_count_q < nsq))
		else $error("load count beyond n*n");

	// Augmenting walk starts on a real column
	a_aug_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_G0) |-> (cur_q != '0))
		else $error("augment from column 0");

	// Every scan finds an unvisited column with finite slack
	a_delta_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_U0) |-> (su_delta != INF) && (su_next != '0))
		else $error("no column chosen by scan");

	// No weight or size write is taken outside the load state
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !s_axis_tready && !cfg_ready)
		else $error("input ready outside load");
`endif

endmodule

`default_nettype wire

// ===== sim/hma_assignment_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hma_assignment_checker
// Predicts and checks the row-to-column assignments of the unit.
// ----------------------------------------------------------------------------
// Watches the configuration, weight and assignment channels. Every accepted
// weight goes into a private copy of the matrix; when a load completes, the
// assignment is solved here and one expected transaction per row is queued.
// Each accepted assignment transaction is compared with the oldest one queued.
// ----------------------------------------------------------------------------
`default_nettype none

module hma_assignment_checker
	import hma_pkg::*;
#(
	parameter int MAX_SIZE = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	input  wire logic                    cfg_ready,
	input  wire logic [SIZE_BITS-1:0]    cfg_data,
	input  wire logic                    s_axis_tvalid,
	input  wire logic                    s_axis_tready,
	input  wire logic [IN_DATA_BITS-1:0] s_axis_tdata,
	input  wire logic                    m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	input  wire logic [2*IDX_BITS-1:0]   m_axis_tdata,
	input  wire logic                    m_axis_tlast,
	output int                           fail_count,
	output int                           pending
);

	localparam longint SLACK_MAX = 64'sh7fff_ffff_ffff_ffff;

	typedef struct packed {
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic                last;
	} row_assign_t;

	row_assign_t assign_q[$];

	logic [SIZE_BITS-1:0]    size_reg;
	logic [IN_DATA_BITS-1:0] weights [MAX_SIZE*MAX_SIZE];
	logic [IN_DATA_BITS-1:0] top_weight;
	int                      loaded;
	longint                  row_pot [MAX_SIZE+1];
	longint                  col_pot [MAX_SIZE+1];
	longint                  slack   [MAX_SIZE+1];
	bit                      seen    [MAX_SIZE+1];
	int                      owner   [MAX_SIZE+1];
	int                      via     [MAX_SIZE+1];

	assign pending = assign_q.size();

	function automatic int matrix_dim();
		if (size_reg == 0)
			return 1;
		if (size_reg > MAX_SIZE)
			return MAX_SIZE;
		return int'(size_reg);
	endfunction

	// Shortest augmenting path on cost = top_weight - weight; queue the result.
	function automatic void solve_assignment(int n);
		int     cur, nxt, row, prev;
		longint delta, c;
		row_assign_t a;
		for (int j = 0; j <= MAX_SIZE; j++) begin
			row_pot[j] = 0;
			col_pot[j] = 0;
			owner[j]   = 0;
			via[j]     = 0;
		end
		for (int r = 1; r <= n; r++) begin
			cur = 0;
			owner[0] = r;
			for (int j = 0; j <= MAX_SIZE; j++) begin
				slack[j] = SLACK_MAX;
				seen[j]  = 0;
			end
			do begin
				seen[cur] = 1;
				row   = owner[cur];
				delta = SLACK_MAX;
				nxt   = 0;
				for (int j = 1; j <= n; j++) begin
					if (!seen[j]) begin
						c = longint'(top_weight) - longint'(weights[(row-1)*n + j-1])
							- row_pot[row] - col_pot[j];
						if (c < slack[j]) begin
							slack[j] = c;
							via[j]   = cur;
						end
						if (slack[j] < delta) begin
							delta = slack[j];
							nxt   = j;
						end
					end
				end
				for (int j = 0; j <= n; j++) begin
					if (seen[j]) begin
						row_pot[owner[j]] += delta;
						col_pot[j]        -= delta;
					end else begin
						slack[j] -= delta;
					end
				end
				cur = nxt;
			end while (owner[cur] != 0);
			do begin
				prev       = via[cur];
				owner[cur] = owner[prev];
				cur        = prev;
			end while (cur != 0);
		end
		for (int r = 0; r < n; r++) begin
			a.row  = r[IDX_BITS-1:0];
			a.col  = '0;
			a.last = (r == n - 1);
			for (int j = 1; j <= n; j++)
				if (owner[j] == r + 1)
					a.col = IDX_BITS'(j - 1);
			assign_q.push_back(a);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int          n;
		row_assign_t got, exp_a;
		if (!arst_n) begin
			size_reg   = 5'd16;
			top_weight = '0;
			loaded     = 0;
			fail_count = 0;
			assign_q.delete();
		end else begin
			// a size write drops any partial load
			if (cfg_valid && cfg_ready) begin
				size_reg   = cfg_data;
				loaded     = 0;
				top_weight = '0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n = matrix_dim();
				if (loaded >= n * n)
					loaded = 0;
				weights[loaded] = s_axis_tdata;
				if (s_axis_tdata > top_weight)
					top_weight = s_axis_tdata;
				loaded++;
				if (loaded == n * n) begin
					solve_assignment(n);
					loaded     = 0;
					top_weight = '0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.row  = m_axis_tdata[IDX_BITS-1:0];
				got.col  = m_axis_tdata[2*IDX_BITS-1:IDX_BITS];
				got.last = m_axis_tlast;
				if (assign_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected assignment row=%0d col=%0d last=%0b",
						$time, got.row, got.col, got.last);
				end else begin
					exp_a = assign_q.pop_front();
					if (got !== exp_a) begin
						fail_count++;
						$display("%0t: expected row=%0d col=%0d last=%0b, got row=%0d col=%0d last=%0b",
							$time, exp_a.row, exp_a.col, exp_a.last,
							got.row, got.col, got.last);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/hungarian_max_weight_assignment_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hungarian_max_weight_assignment_unit_tb
// Stimulus and verdict for the max-weight assignment unit.
// ----------------------------------------------------------------------------
// Loads weight matrices of several sizes, with random gaps on the weight stream
// and random stalls on the assignment stream. A directed part covers a full
// 16 by 16 load, out-of-range sizes, a load dropped by a size write, weight
// extremes and ties; then a short run of small random matrices follows. The
// checker beside the unit predicts each assignment and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module hungarian_max_weight_assignment_unit_tb;
	import hma_pkg::*;

	localparam int MAX_SIZE     = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_WAIT  = 40;
	localparam int RANDOM_ITEMS = 40;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [SIZE_BITS-1:0]    cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;   // [15:0] weight
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [2*IDX_BITS-1:0]   m_axis_tdata;        // [3:0] row_index, [7:4] column_index
	logic                    m_axis_tlast;

	int fail_count;
	int pending;
	int cycles = 0;
	bit no_idle = 1'b0;   // hold both sides busy during a quiet stretch
	int stall_left = 0;
	int items = 0;

	always #6 clk = ~clk;

	hungarian_max_weight_assignment_unit #(
		.MAX_SIZE(MAX_SIZE),
		.WEIGHT_BITS(IN_DATA_BITS)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	hma_assignment_checker #(.MAX_SIZE(MAX_SIZE)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: after each accepted transaction draw a random stall.
	always @(posedge clk) begin
		int draw;
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= (stall_left == 1);
			end else if (m_axis_tvalid && m_axis_tready) begin
				draw          = no_idle ? 0 : $urandom_range(0, 7);
				stall_left    <= draw;
				m_axis_tready <= (draw == 0);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Send one weight; keep tvalid up across back-to-back transactions.
	task automatic send_weight(input logic [IN_DATA_BITS-1:0] w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items++;
	endtask

	// Drain outstanding assignments, let the unit settle, then write the size.
	task automatic write_size(input logic [SIZE_BITS-1:0] sz);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sz;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int dim_of(input logic [SIZE_BITS-1:0] sz);
		if (sz == 0)
			return 1;
		if (sz > MAX_SIZE)
			return MAX_SIZE;
		return int'(sz);
	endfunction

	initial begin
		int n, kind, cnt;
		logic [SIZE_BITS-1:0] sz;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full 16 by 16 load at the reset size, mixing all-ones, all-zero and random weights.
		for (int i = 0; i < MAX_SIZE * MAX_SIZE; i++)
			send_weight((i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'h0000
				: IN_DATA_BITS'($urandom));
		// Largest size code acts as 16; drop the partial load with a write of 0.
		write_size(5'd31);
		for (int i = 0; i < 5; i++)
			send_weight(IN_DATA_BITS'($urandom));
		write_size(5'd0);
		send_weight(16'h0000);
		send_weight(16'hffff);
		// Size 2: all ties, then a cross preference, then extremes.
		write_size(5'd2);
		repeat (4) send_weight(16'h0007);
		send_weight(16'h0000); send_weight(16'hffff);
		send_weight(16'hffff); send_weight(16'h0000);
		send_weight(16'hffff); send_weight(16'hffff);
		send_weight(16'h0000); send_weight(16'hffff);

		// Small random matrices; now and then a load cut short.
		items = 0;
		while (items < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			sz = ($urandom_range(0, 19) == 0) ? 5'd0 : SIZE_BITS'($urandom_range(1, 6));
			write_size(sz);
			n    = dim_of(sz);
			kind = $urandom_range(0, 3);
			cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n * n - 1) : n * n;
			for (int i = 0; i < cnt; i++) begin
				case (kind)
					0: begin
						send_weight(IN_DATA_BITS'($urandom_range(0, 3)));
					end
					1: begin
						send_weight(16'h00aa);
					end
					default: begin
						send_weight(IN_DATA_BITS'($urandom));
					end
				endcase
			end
		end

		no_idle = 1'b0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
